FILE: rtl/core/string_interleave_check_top_defines.svh
// Assertion macros used by the top module to check the design.
`ifndef STRING_INTERLEAVE_CHECK_TOP_DEFINES_SVH
`define STRING_INTERLEAVE_CHECK_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("string_interleave_check: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SIC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("string_interleave_check: next-cycle check failed");

`endif

FILE: rtl/core/sic_pkg.sv
package sic_pkg;

   localparam int MAX_LEN_A = 64;
   localparam int MAX_LEN_B = 64;
   localparam int CAP_C     = MAX_LEN_A + MAX_LEN_B;

   localparam int LEN_A_W = $clog2(MAX_LEN_A + 1);
   localparam int LEN_B_W = $clog2(MAX_LEN_B + 1);
   localparam int LEN_C_W = $clog2(CAP_C + 1);
   localparam int A_IDX_W = (MAX_LEN_A > 1) ? $clog2(MAX_LEN_A) : 1;
   localparam int B_IDX_W = (MAX_LEN_B > 1) ? $clog2(MAX_LEN_B) : 1;
   localparam int C_IDX_W = $clog2(CAP_C);
   localparam int T_IDX_W = LEN_B_W;
   localparam int TBL_DEPTH = MAX_LEN_B + 1;

   localparam logic [1:0] FUNC_APPEND_A = 2'd0;
   localparam logic [1:0] FUNC_APPEND_B = 2'd1;
   localparam logic [1:0] FUNC_APPEND_C = 2'd2;
   localparam logic [1:0] FUNC_EVAL     = 2'd3;

   localparam logic [1:0] FLAG_A = 2'b01;
   localparam logic [1:0] FLAG_B = 2'b10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_DONE
   } sic_state_type;

   typedef struct packed {
      logic [A_IDX_W-1:0] a_addr;
      logic [B_IDX_W-1:0] b_addr;
      logic [C_IDX_W-1:0] c_addr;
      logic [T_IDX_W-1:0] t_addr;
      logic               calc;
      logic               first_row;
      logic               first_col;
   } sic_ctrl_type;

   typedef struct packed {
      logic [LEN_A_W-1:0] len_a;
      logic [LEN_B_W-1:0] len_b;
      logic [LEN_C_W-1:0] len_c;
      logic               overflow;
   } sic_status_type;

   typedef struct packed {
      logic [7:0] sa;
      logic [7:0] sb;
      logic [7:0] sc;
   } sic_syms_type;

endpackage

FILE: rtl/core/string_interleave_check_top.sv
// Decides whether string C is an interleaving of strings A and B. Each beat on
// the request channel either appends req_sym to A, B or C, or evaluates and
// clears all three lengths. Append beats produce no response. An evaluate beat
// produces one response beat: if a string overflowed since the last evaluate,
// or the length of C is not the sum of the other two, the response is
// registered in the next cycle; otherwise a single cell unit walks the table of
// (len_a + 1) * (len_b + 1) cells, each cell in the ST_READ state, which reads
// the registered string and row memories, and then the ST_CALC state, which
// updates the cell, and req_ready stays low until the response is registered.
// Appends are still taken while a response waits on rsp_ready.
`include "string_interleave_check_top_defines.svh"

module string_interleave_check_top
   import sic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_sym,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_interleaving,
   output logic       rsp_overflow
);

   sic_ctrl_type   ctrl;
   sic_status_type status;
   sic_syms_type   syms;
   logic           cell_nz;
   logic           append_en;
   logic           clear;

   sic_strings u_strings (
      .clock     (clock),
      .reset     (reset),
      .append_en (append_en),
      .func      (req_func),
      .sym       (req_sym),
      .clear     (clear),
      .ctrl      (ctrl),
      .status    (status),
      .syms      (syms)
   );

   sic_cell_unit u_cell_unit (
      .clock   (clock),
      .ctrl    (ctrl),
      .syms    (syms),
      .cell_nz (cell_nz)
   );

   sic_sequencer u_sequencer (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_func            (req_func),
      .req_ready           (req_ready),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_is_interleaving (rsp_is_interleaving),
      .rsp_overflow        (rsp_overflow),
      .status              (status),
      .cell_nz             (cell_nz),
      .append_en           (append_en),
      .clear               (clear),
      .ctrl                (ctrl)
   );

   `SIC_ASSERT_SAME(a_ovf_forces_false, rsp_valid && rsp_overflow, !rsp_is_interleaving)
   `SIC_ASSERT_NEXT(a_ovf_eval_reports, req_valid && req_ready && (req_func == FUNC_EVAL) && status.overflow, rsp_valid && rsp_overflow && (status.overflow == 1'b0))
   `SIC_ASSERT_SAME(a_busy_not_ready, ctrl.calc, !req_ready && !append_en)
   `SIC_ASSERT_NEXT(a_clear_lengths, clear, (status.len_a == '0) && (status.len_c == '0))

endmodule

FILE: rtl/core/sic_strings.sv
module sic_strings
   import sic_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           append_en,
   input  logic [1:0]     func,
   input  logic [7:0]     sym,
   input  logic           clear,
   input  sic_ctrl_type   ctrl,
   output sic_status_type status,
   output sic_syms_type   syms
);

   logic [7:0] store_a [MAX_LEN_A];
   logic [7:0] store_b [MAX_LEN_B];
   logic [7:0] store_c [CAP_C];

   logic [LEN_A_W-1:0] len_a_ff, len_a_in;
   logic [LEN_B_W-1:0] len_b_ff, len_b_in;
   logic [LEN_C_W-1:0] len_c_ff, len_c_in;
   logic               overflow_ff, overflow_in;
   logic               wr_a, wr_b, wr_c;
   logic [7:0]         sa_ff, sb_ff, sc_ff;

   always_comb begin
      len_a_in    = len_a_ff;
      len_b_in    = len_b_ff;
      len_c_in    = len_c_ff;
      overflow_in = overflow_ff;
      wr_a        = 1'b0;
      wr_b        = 1'b0;
      wr_c        = 1'b0;
      if (clear) begin
         len_a_in    = '0;
         len_b_in    = '0;
         len_c_in    = '0;
         overflow_in = 1'b0;
      end else if (append_en) begin
         unique case (func)
            FUNC_APPEND_A: begin
               if (len_a_ff < LEN_A_W'(MAX_LEN_A)) begin
                  wr_a     = 1'b1;
                  len_a_in = len_a_ff + LEN_A_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
            FUNC_APPEND_B: begin
               if (len_b_ff < LEN_B_W'(MAX_LEN_B)) begin
                  wr_b     = 1'b1;
                  len_b_in = len_b_ff + LEN_B_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
            FUNC_APPEND_C: begin
               if (len_c_ff < LEN_C_W'(CAP_C)) begin
                  wr_c     = 1'b1;
                  len_c_in = len_c_ff + LEN_C_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff    <= '0;
         len_b_ff    <= '0;
         len_c_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         len_a_ff    <= len_a_in;
         len_b_ff    <= len_b_in;
         len_c_ff    <= len_c_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         store_a[len_a_ff[A_IDX_W-1:0]] <= sym;
      end
      if (wr_b) begin
         store_b[len_b_ff[B_IDX_W-1:0]] <= sym;
      end
      if (wr_c) begin
         store_c[len_c_ff[C_IDX_W-1:0]] <= sym;
      end
      sa_ff <= store_a[ctrl.a_addr];
      sb_ff <= store_b[ctrl.b_addr];
      sc_ff <= store_c[ctrl.c_addr];
   end

   assign status.len_a    = len_a_ff;
   assign status.len_b    = len_b_ff;
   assign status.len_c    = len_c_ff;
   assign status.overflow = overflow_ff;
   assign syms.sa         = sa_ff;
   assign syms.sb         = sb_ff;
   assign syms.sc         = sc_ff;

endmodule

FILE: rtl/core/sic_cell_unit.sv
module sic_cell_unit
   import sic_pkg::*;
(
   input  logic         clock,
   input  sic_ctrl_type ctrl,
   input  sic_syms_type syms,
   output logic         cell_nz
);

   logic [1:0] table_row [TBL_DEPTH];
   logic [1:0] top_ff;
   logic [1:0] left_ff;
   logic [1:0] cell_val;
   logic       match_a;
   logic       match_b;

   assign match_a = (syms.sa == syms.sc);
   assign match_b = (syms.sb == syms.sc);

   always_comb begin
      cell_val = '0;
      if (ctrl.first_row && ctrl.first_col) begin
         cell_val = FLAG_A | FLAG_B;
      end else if (ctrl.first_row) begin
         if ((left_ff != 2'b00) && match_b) begin
            cell_val = FLAG_A | FLAG_B;
         end
      end else if (ctrl.first_col) begin
         if ((top_ff != 2'b00) && match_a) begin
            cell_val = FLAG_A | FLAG_B;
         end
      end else begin
         if (match_a && (top_ff != 2'b00)) begin
            cell_val = cell_val | FLAG_A;
         end
         if (match_b && (left_ff != 2'b00)) begin
            cell_val = cell_val | FLAG_B;
         end
      end
   end

   assign cell_nz = (cell_val != 2'b00);

   always_ff @(posedge clock) begin
      if (ctrl.calc) begin
         table_row[ctrl.t_addr] <= cell_val;
         left_ff                <= cell_val;
      end
      top_ff <= table_row[ctrl.t_addr];
   end

endmodule

FILE: rtl/core/sic_sequencer.sv
module sic_sequencer
   import sic_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_func,
   output logic           req_ready,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output logic           rsp_is_interleaving,
   output logic           rsp_overflow,
   input  sic_status_type status,
   input  logic           cell_nz,
   output logic           append_en,
   output logic           clear,
   output sic_ctrl_type   ctrl
);

   sic_state_type      state_ff, state_in;
   logic [LEN_A_W-1:0] i_ff, i_in;
   logic [LEN_B_W-1:0] j_ff, j_in;
   logic               verdict_ff, verdict_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_isl_ff, rsp_isl_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic               out_free;
   logic [LEN_C_W-1:0] len_sum;
   logic [LEN_A_W-1:0] a_tmp;
   logic [LEN_B_W-1:0] b_tmp;
   logic [LEN_C_W-1:0] c_tmp;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign len_sum  = LEN_C_W'(status.len_a) + LEN_C_W'(status.len_b);

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_isl_in   = rsp_isl_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      req_ready    = 1'b0;
      append_en    = 1'b0;
      clear        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = (req_func != FUNC_EVAL) || out_free;
            if (req_valid && req_ready) begin
               if (req_func != FUNC_EVAL) begin
                  append_en = 1'b1;
               end else if (status.overflow) begin
                  rsp_valid_in = 1'b1;
                  rsp_isl_in   = 1'b0;
                  rsp_ovf_in   = 1'b1;
                  clear        = 1'b1;
               end else if (len_sum != status.len_c) begin
                  rsp_valid_in = 1'b1;
                  rsp_isl_in   = 1'b0;
                  rsp_ovf_in   = 1'b0;
                  clear        = 1'b1;
               end else begin
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (j_ff != status.len_b) begin
               j_in     = j_ff + LEN_B_W'(1);
               state_in = ST_READ;
            end else if (i_ff != status.len_a) begin
               i_in     = i_ff + LEN_A_W'(1);
               j_in     = '0;
               state_in = ST_READ;
            end else begin
               verdict_in = cell_nz;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_isl_in   = verdict_ff;
               rsp_ovf_in   = 1'b0;
               clear        = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      a_tmp          = i_ff - LEN_A_W'(1);
      b_tmp          = j_ff - LEN_B_W'(1);
      c_tmp          = LEN_C_W'(i_ff) + LEN_C_W'(j_ff) - LEN_C_W'(1);
      ctrl.a_addr    = a_tmp[A_IDX_W-1:0];
      ctrl.b_addr    = b_tmp[B_IDX_W-1:0];
      ctrl.c_addr    = c_tmp[C_IDX_W-1:0];
      ctrl.t_addr    = j_ff;
      ctrl.calc      = (state_ff == ST_CALC);
      ctrl.first_row = (i_ff == '0);
      ctrl.first_col = (j_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      verdict_ff <= verdict_in;
      rsp_isl_ff <= rsp_isl_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_interleaving = rsp_isl_ff;
   assign rsp_overflow        = rsp_ovf_ff;

endmodule

FILE: tb/interleave_verdict_checker.sv
`timescale 1ns / 1ps

module interleave_verdict_checker
   import sic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_sym,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_is_interleaving,
   input  logic       rsp_overflow,
   output int         fail_count,
   output int         verdicts_owed
);

   typedef struct packed {
      logic interleaved;
      logic overflowed;
   } verdict_type;

   logic [7:0]  held_a [MAX_LEN_A];
   logic [7:0]  held_b [MAX_LEN_B];
   logic [7:0]  held_c [CAP_C];
   int          cnt_a;
   int          cnt_b;
   int          cnt_c;
   logic        spilled;
   verdict_type verdicts_due [$];
   verdict_type want;

   initial begin
      fail_count = 0;
      verdicts_owed = 0;
   end

   function automatic logic interleaves();
      logic [1:0] row [TBL_DEPTH];
      logic [7:0] sa;
      logic [7:0] sc;
      logic [1:0] cell_val;
      int         i;
      int         j;
      if (cnt_a + cnt_b != cnt_c) return 1'b0;
      row[0] = FLAG_A | FLAG_B;
      for (j = 1; j <= cnt_b; j++) begin
         row[j] = (row[j-1] != 2'b00 && held_b[j-1] == held_c[j-1]) ? (FLAG_A | FLAG_B) : 2'b00;
      end
      for (i = 1; i <= cnt_a; i++) begin
         sa = held_a[i-1];
         row[0] = (row[0] != 2'b00 && sa == held_c[i-1]) ? (FLAG_A | FLAG_B) : 2'b00;
         for (j = 1; j <= cnt_b; j++) begin
            sc = held_c[i+j-1];
            cell_val = 2'b00;
            if (sa == sc && row[j] != 2'b00) cell_val = cell_val | FLAG_A;
            if (held_b[j-1] == sc && row[j-1] != 2'b00) cell_val = cell_val | FLAG_B;
            row[j] = cell_val;
         end
      end
      return row[cnt_b] != 2'b00;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cnt_a = 0;
         cnt_b = 0;
         cnt_c = 0;
         spilled = 1'b0;
         verdicts_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: response beat with nothing expected: expected none, actual %b/%b",
                        $time, rsp_is_interleaving, rsp_overflow);
               fail_count++;
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_is_interleaving !== want.interleaved) begin
                  $display("%0t: is_interleaving mismatch: expected %b, actual %b",
                           $time, want.interleaved, rsp_is_interleaving);
                  fail_count++;
               end
               if (rsp_overflow !== want.overflowed) begin
                  $display("%0t: overflow mismatch: expected %b, actual %b",
                           $time, want.overflowed, rsp_overflow);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_func)
               FUNC_APPEND_A: begin
                  if (cnt_a < MAX_LEN_A) begin
                     held_a[cnt_a] = req_sym;
                     cnt_a++;
                  end else begin
                     spilled = 1'b1;
                  end
               end
               FUNC_APPEND_B: begin
                  if (cnt_b < MAX_LEN_B) begin
                     held_b[cnt_b] = req_sym;
                     cnt_b++;
                  end else begin
                     spilled = 1'b1;
                  end
               end
               FUNC_APPEND_C: begin
                  if (cnt_c < CAP_C) begin
                     held_c[cnt_c] = req_sym;
                     cnt_c++;
                  end else begin
                     spilled = 1'b1;
                  end
               end
               FUNC_EVAL: begin
                  want.overflowed = spilled;
                  want.interleaved = spilled ? 1'b0 : interleaves();
                  verdicts_due.push_back(want);
                  cnt_a = 0;
                  cnt_b = 0;
                  cnt_c = 0;
                  spilled = 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
      verdicts_owed = verdicts_due.size();
   end

endmodule

FILE: tb/tb_string_interleave_check_top.sv
`timescale 1ns / 1ps

module tb_string_interleave_check_top;
   import sic_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   localparam int STALL_LIMIT  = 40000;
   localparam int DRAIN_CYCLES = 2 * (MAX_LEN_A + 1) * (MAX_LEN_B + 1) + 16;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_func = FUNC_APPEND_A;
   logic [7:0] req_sym = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_is_interleaving;
   logic       rsp_overflow;

   int         fail_count;
   int         verdicts_owed;
   int         items_sent = 0;
   int         idle_pct = 0;
   int         stall_pct = 0;
   int         quiet_cycles = 0;
   logic [7:0] job_a [$];
   logic [7:0] job_b [$];
   logic [7:0] job_c [$];

   string_interleave_check_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_sym             (req_sym),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_is_interleaving (rsp_is_interleaving),
      .rsp_overflow        (rsp_overflow)
   );

   interleave_verdict_checker verdicts (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_sym             (req_sym),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_is_interleaving (rsp_is_interleaving),
      .rsp_overflow        (rsp_overflow),
      .fail_count          (fail_count),
      .verdicts_owed       (verdicts_owed)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_string_interleave_check_top NOT OK");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_beat(input logic [1:0] f, input logic [7:0] s);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_sym <= s;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic build_job();
      int         kind;
      int         which;
      int         la;
      int         lb;
      int         ia;
      int         ib;
      int         pos;
      logic       narrow;
      logic [7:0] s0;
      logic [7:0] s1;
      logic [7:0] t;
      job_a.delete();
      job_b.delete();
      job_c.delete();
      kind = $urandom_range(99);
      which = $urandom_range(2);
      if ($urandom_range(99) < 3) begin
         if ($urandom_range(3) == 0) begin
            la = MAX_LEN_A;
            lb = MAX_LEN_B;
         end else begin
            la = $urandom_range(MAX_LEN_A);
            lb = $urandom_range(MAX_LEN_B);
         end
      end else begin
         la = $urandom_range(6);
         lb = $urandom_range(6);
      end
      if (kind >= 98 && which == 0) la = MAX_LEN_A + $urandom_range(1, 3);
      if (kind >= 98 && which == 1) lb = MAX_LEN_B + $urandom_range(1, 3);
      narrow = $urandom_range(1);
      s0 = 8'($urandom);
      s1 = 8'($urandom);
      for (ia = 0; ia < la; ia++) job_a.push_back(narrow ? ($urandom_range(1) ? s1 : s0) : 8'($urandom));
      for (ib = 0; ib < lb; ib++) job_b.push_back(narrow ? ($urandom_range(1) ? s1 : s0) : 8'($urandom));
      ia = 0;
      ib = 0;
      while (ia < la || ib < lb) begin
         if (ib >= lb || (ia < la && $urandom_range(1))) begin
            job_c.push_back(job_a[ia]);
            ia++;
         end else begin
            job_c.push_back(job_b[ib]);
            ib++;
         end
      end
      if (kind >= 70 && kind < 80 && job_c.size() > 0) begin
         pos = $urandom_range(job_c.size() - 1);
         job_c[pos] = job_c[pos] ^ 8'(1 << $urandom_range(7));
      end else if (kind >= 80 && kind < 88) begin
         if ($urandom_range(1) && job_c.size() > 0) job_c.pop_back();
         else job_c.push_back(8'($urandom));
      end else if (kind >= 88 && kind < 93 && job_c.size() >= 2) begin
         pos = $urandom_range(job_c.size() - 2);
         t = job_c[pos];
         job_c[pos] = job_c[pos+1];
         job_c[pos+1] = t;
      end else if (kind >= 93 && kind < 98) begin
         for (pos = 0; pos < job_c.size(); pos++) begin
            job_c[pos] = narrow ? ($urandom_range(1) ? s1 : s0) : 8'($urandom);
         end
      end else if (kind >= 98 && which == 2) begin
         pos = CAP_C + $urandom_range(1, 3);
         while (job_c.size() < pos) job_c.push_back(8'($urandom));
      end
   endtask

   task automatic run_job();
      int ia;
      int ib;
      int ic;
      int pick;
      ia = 0;
      ib = 0;
      ic = 0;
      while (ia < job_a.size() || ib < job_b.size() || ic < job_c.size()) begin
         pick = $urandom_range(2);
         if (pick == 0 && ia < job_a.size()) begin
            send_beat(FUNC_APPEND_A, job_a[ia]);
            ia++;
         end else if (pick == 1 && ib < job_b.size()) begin
            send_beat(FUNC_APPEND_B, job_b[ib]);
            ib++;
         end else if (pick == 2 && ic < job_c.size()) begin
            send_beat(FUNC_APPEND_C, job_c[ic]);
            ic++;
         end
      end
      send_beat(FUNC_EVAL, 8'($urandom));
   endtask

   initial begin
      int start;
      int phase;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_beat(FUNC_EVAL, 8'hFF);

      send_beat(FUNC_APPEND_A, 8'h00);
      send_beat(FUNC_APPEND_C, 8'h00);
      send_beat(FUNC_EVAL, 8'h00);

      send_beat(FUNC_APPEND_B, 8'hFF);
      send_beat(FUNC_APPEND_C, 8'hFF);
      send_beat(FUNC_EVAL, 8'h55);

      send_beat(FUNC_APPEND_B, 8'h00);
      send_beat(FUNC_APPEND_A, 8'hFF);
      send_beat(FUNC_APPEND_C, 8'h00);
      send_beat(FUNC_APPEND_C, 8'hFF);
      send_beat(FUNC_EVAL, 8'hAA);

      send_beat(FUNC_APPEND_A, 8'h55);
      send_beat(FUNC_APPEND_C, 8'hAA);
      send_beat(FUNC_EVAL, 8'h00);

      send_beat(FUNC_APPEND_A, 8'h01);
      send_beat(FUNC_APPEND_C, 8'h01);
      send_beat(FUNC_APPEND_C, 8'h01);
      send_beat(FUNC_EVAL, 8'h00);

      send_beat(FUNC_APPEND_A, 8'h12);
      send_beat(FUNC_APPEND_A, 8'h34);
      send_beat(FUNC_APPEND_B, 8'h12);
      send_beat(FUNC_APPEND_C, 8'h12);
      send_beat(FUNC_APPEND_C, 8'h12);
      send_beat(FUNC_APPEND_C, 8'h34);
      send_beat(FUNC_EVAL, 8'h00);

      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         phase = ((items_sent - start) * 4) / RANDOM_ITEMS;
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 72;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 72;
            end
            default: begin
               idle_pct = 6;
               stall_pct = 6;
            end
         endcase
         build_job();
         run_job();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_string_interleave_check_top OK");
      end else begin
         $display("tb_string_interleave_check_top NOT OK");
      end
      $finish;
   end

endmodule
